/* rtl/tmhs_pkg.sv */
// Shared constants, request and status codes for the timer min-heap scheduler.
// Depends on nothing; the top level imports it.
package tmhs_pkg;

    localparam int ID_W         = 12;
    localparam int ID_SPACE     = 4096;
    localparam int REQ_W        = 2;
    localparam int DELAY_W      = 31;
    localparam int NOW_W        = 48;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 13;
    localparam int PROD_W       = 41;
    localparam int SUM_W        = 66;
    localparam int MS_TO_US     = 1000;
    localparam int DEF_CAPACITY = 4096;
    localparam int DEF_TIME_BITS = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_POLL   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_ACTIVE  = 3'd3,
        ST_NOT_DUE = 3'd4,
        ST_EXPIRED = 3'd5,
        ST_EMPTY   = 3'd6
    } t_status;

endpackage

/* rtl/tmhs_heap_ram.sv */
// Heap entry store: one write port and two registered read ports.
// Depends on nothing but its parameters.
module tmhs_heap_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 60
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_a,
    output logic [DATA_W-1:0]        o_rdata_b
);
    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

/* rtl/timer_min_heap_scheduler.sv */
// Top level of the timer min-heap scheduler: request sequencer, id map memory
// and the heap store (tmhs_heap_ram). Uses tmhs_pkg.
//
// Pending timers live in a binary min-heap ordered by deadline, kept in a
// synchronous memory; a second memory maps each timer id to its heap slot
// plus an active flag. A request is one input beat and always gives one
// result beat. An insert climbs from the new last slot toward the root;
// cancel and an expiring poll move the last entry into the hole, walk it
// down and then up, and end at once when the removed entry is the last
// one; other requests only look up and report. Each heap level costs a
// memory read state and a compare/write state; in a full 4096-entry heap
// the longest walk comes when equal deadlines walk an entry down to a leaf
// and back up to the root. After reset the block clears the id map, one
// entry a cycle, and stalls input until that is done. A finished result
// sits in an output register, so the next request is taken while the
// previous result waits.
module timer_min_heap_scheduler #(
    parameter int CAPACITY  = tmhs_pkg::DEF_CAPACITY,
    parameter int TIME_BITS = tmhs_pkg::DEF_TIME_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tmhs_pkg::REQ_W-1:0]    i_req_type,
    input  logic [tmhs_pkg::ID_W-1:0]     i_timer_id,
    input  logic [tmhs_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic [tmhs_pkg::NOW_W-1:0]    i_now_us,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tmhs_pkg::STATUS_W-1:0] o_status,
    output logic [tmhs_pkg::ID_W-1:0]     o_expired_id,
    output logic [tmhs_pkg::NOW_W-1:0]    o_wait_us,
    output logic [tmhs_pkg::COUNT_W-1:0]  o_active_count
);
    import tmhs_pkg::*;

    localparam int POS_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = POS_W + 2;
    localparam int DATA_W = TIME_BITS + ID_W;
    localparam int IDM_W  = POS_W + 1;
    localparam int IDX_W  = $clog2(ID_SPACE);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_LOOK   = 11'b000_0000_0100,
        S_REM    = 11'b000_0000_1000,
        S_LAST   = 11'b000_0001_0000,
        S_DN_REQ = 11'b000_0010_0000,
        S_DN_CMP = 11'b000_0100_0000,
        S_UP_REQ = 11'b000_1000_0000,
        S_UP_CMP = 11'b001_0000_0000,
        S_PLACE  = 11'b010_0000_0000,
        S_FIN    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // request latch
    t_req                 r_req;
    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_now;
    logic [PROD_W-1:0]    r_prod;

    // heap walk
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [POS_W-1:0]     r_pos, n_pos;
    logic [TIME_BITS-1:0] r_x_dl, n_x_dl;
    logic [ID_W-1:0]      r_x_id, n_x_id;
    logic [ID_W-1:0]      r_rm_id, n_rm_id;
    logic [POS_W-1:0]     r_hole, n_hole;

    // pending result
    t_status              r_res_status, n_res_status;
    logic [ID_W-1:0]      r_res_exp, n_res_exp;
    logic [NOW_W-1:0]     r_res_wait, n_res_wait;

    // clearing pass
    logic [IDX_W-1:0]     r_clr_idx;

    // output register
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_o_status;
    logic [ID_W-1:0]      r_o_exp;
    logic [NOW_W-1:0]     r_o_wait;
    logic [COUNT_W-1:0]   r_o_count;

    // memories
    logic [IDM_W-1:0]     r_idm [ID_SPACE];
    logic [IDM_W-1:0]     r_idm_rd;
    logic                 idm_we;
    logic [IDX_W-1:0]     idm_waddr, idm_raddr;
    logic [IDM_W-1:0]     idm_wdata;

    logic                 heap_we;
    logic [POS_W-1:0]     heap_waddr, heap_raddr_a, heap_raddr_b;
    logic [DATA_W-1:0]    heap_wdata, heap_rd_a, heap_rd_b;

    logic                 in_accept, out_free;
    logic [SUM_W-1:0]     sum;
    logic [TIME_BITS-1:0] new_dl;
    logic [CMP_W-1:0]     kid, kid1, cnt_x;
    logic [CNT_W-1:0]     last_n;
    logic [POS_W-1:0]     par;
    logic [TIME_BITS-1:0] a_dl, b_dl;
    logic                 take_right;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    // deadline: now plus delay in microseconds, saturated
    assign sum    = SUM_W'(r_now) + SUM_W'(r_prod);
    assign new_dl = ((sum >> TIME_BITS) != '0) ? '1 : TIME_BITS'(sum);

    assign kid    = CMP_W'({r_pos, 1'b1});
    assign kid1   = kid + CMP_W'(1);
    assign cnt_x  = CMP_W'(r_cnt);
    assign last_n = r_cnt - CNT_W'(1);
    assign par    = (r_pos - POS_W'(1)) >> 1;
    assign a_dl   = heap_rd_a[DATA_W-1:ID_W];
    assign b_dl   = heap_rd_b[DATA_W-1:ID_W];
    assign take_right = (kid1 < cnt_x) && (a_dl > b_dl);

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pos        = r_pos;
        n_x_dl       = r_x_dl;
        n_x_id       = r_x_id;
        n_rm_id      = r_rm_id;
        n_hole       = r_hole;
        n_res_status = r_res_status;
        n_res_exp    = r_res_exp;
        n_res_wait   = r_res_wait;
        idm_we       = 1'b0;
        idm_waddr    = IDX_W'(r_x_id);
        idm_wdata    = {1'b1, r_pos};
        idm_raddr    = IDX_W'(i_timer_id);
        heap_we      = 1'b0;
        heap_waddr   = r_pos;
        heap_wdata   = {r_x_dl, r_x_id};
        heap_raddr_a = '0;
        heap_raddr_b = '0;

        case (r_state)
            S_CLEAR: begin
                idm_we    = 1'b1;
                idm_waddr = r_clr_idx;
                idm_wdata = '0;
                if (r_clr_idx == IDX_W'(ID_SPACE - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_res_status = ST_OK;
                n_res_exp    = '0;
                n_res_wait   = '0;
                n_state      = S_FIN;
                case (r_req)
                    REQ_INSERT: begin
                        if (r_cnt == CNT_W'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                        end else if (r_idm_rd[POS_W]) begin
                            n_res_status = ST_ACTIVE;
                        end else begin
                            n_x_dl  = new_dl;
                            n_x_id  = r_id;
                            n_pos   = POS_W'(r_cnt);
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_state = S_UP_REQ;
                        end
                    end
                    REQ_CANCEL: begin
                        if (!r_idm_rd[POS_W]) begin
                            n_res_status = ST_UNKNOWN;
                        end else begin
                            n_rm_id = r_id;
                            n_hole  = r_idm_rd[POS_W-1:0];
                            n_state = S_REM;
                        end
                    end
                    REQ_POLL: begin
                        if (r_cnt == '0) begin
                            n_res_status = ST_EMPTY;
                        end else if (a_dl < r_now) begin
                            n_res_status = ST_EXPIRED;
                            n_res_exp    = heap_rd_a[ID_W-1:0];
                            n_rm_id      = heap_rd_a[ID_W-1:0];
                            n_hole       = '0;
                            n_state      = S_REM;
                        end else begin
                            n_res_status = ST_NOT_DUE;
                            n_res_wait   = NOW_W'(a_dl - r_now);
                        end
                    end
                    default: begin
                        n_res_status = ST_OK;
                    end
                endcase
            end
            S_REM: begin
                // retire the id, shrink, fetch the last entry if a hole remains
                idm_we       = 1'b1;
                idm_waddr    = IDX_W'(r_rm_id);
                idm_wdata    = '0;
                n_cnt        = last_n;
                heap_raddr_a = POS_W'(last_n);
                if (CNT_W'(r_hole) >= last_n) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_x_dl  = a_dl;
                n_x_id  = heap_rd_a[ID_W-1:0];
                n_pos   = r_hole;
                n_state = S_DN_REQ;
            end
            S_DN_REQ: begin
                heap_raddr_a = POS_W'(kid);
                heap_raddr_b = POS_W'(kid1);
                if (kid >= cnt_x) begin
                    n_state = S_UP_REQ;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (take_right) begin
                    if (r_x_dl < b_dl) begin
                        n_state = S_UP_REQ;
                    end else begin
                        heap_we    = 1'b1;
                        heap_wdata = heap_rd_b;
                        idm_we     = 1'b1;
                        idm_waddr  = IDX_W'(heap_rd_b[ID_W-1:0]);
                        n_pos      = POS_W'(kid1);
                        n_state    = S_DN_REQ;
                    end
                end else begin
                    if (r_x_dl < a_dl) begin
                        n_state = S_UP_REQ;
                    end else begin
                        heap_we    = 1'b1;
                        heap_wdata = heap_rd_a;
                        idm_we     = 1'b1;
                        idm_waddr  = IDX_W'(heap_rd_a[ID_W-1:0]);
                        n_pos      = POS_W'(kid);
                        n_state    = S_DN_REQ;
                    end
                end
            end
            S_UP_REQ: begin
                heap_raddr_a = par;
                if (r_pos == '0) begin
                    n_state = S_PLACE;
                end else begin
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                // ties climb: stop only on a strictly earlier parent
                if (a_dl < r_x_dl) begin
                    n_state = S_PLACE;
                end else begin
                    heap_we    = 1'b1;
                    heap_wdata = heap_rd_a;
                    idm_we     = 1'b1;
                    idm_waddr  = IDX_W'(heap_rd_a[ID_W-1:0]);
                    n_pos      = par;
                    n_state    = S_UP_REQ;
                end
            end
            S_PLACE: begin
                heap_we = 1'b1;
                idm_we  = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req  <= t_req'(i_req_type);
            r_id   <= i_timer_id;
            r_now  <= TIME_BITS'(i_now_us);
            r_prod <= PROD_W'(i_delay_ms) * PROD_W'(MS_TO_US);
        end
        r_pos        <= n_pos;
        r_x_dl       <= n_x_dl;
        r_x_id       <= n_x_id;
        r_rm_id      <= n_rm_id;
        r_hole       <= n_hole;
        r_res_status <= n_res_status;
        r_res_exp    <= n_res_exp;
        r_res_wait   <= n_res_wait;
        if (r_state == S_FIN && out_free) begin
            r_o_status <= r_res_status;
            r_o_exp    <= r_res_exp;
            r_o_wait   <= r_res_wait;
            r_o_count  <= COUNT_W'(r_cnt);
        end
    end

    // id map: active flag and heap slot per timer id
    always_ff @(posedge i_clk) begin
        if (idm_we) begin
            r_idm[idm_waddr] <= idm_wdata;
        end
        r_idm_rd <= r_idm[idm_raddr];
    end

    // port a reads the root while a request is taken
    tmhs_heap_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (DATA_W)
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (heap_we),
        .i_waddr   (heap_waddr),
        .i_wdata   (heap_wdata),
        .i_raddr_a (heap_raddr_a),
        .i_raddr_b (heap_raddr_b),
        .o_rdata_a (heap_rd_a),
        .o_rdata_b (heap_rd_b)
    );

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_expired_id   = r_o_exp;
    assign o_wait_us      = r_o_wait;
    assign o_active_count = r_o_count;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(CAPACITY))
        else $error("pending count above capacity");

    a_up_climbs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP && heap_we) |=> r_pos < $past(r_pos))
        else $error("sift up did not move toward the root");

    a_dn_descends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_CMP && heap_we) |=> r_pos > $past(r_pos))
        else $error("sift down did not move toward the leaves");

    a_wait_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_NOT_DUE) |-> o_wait_us == '0)
        else $error("wait reported on a request that is not a pending poll");
endmodule

/* tb/tb_timer_min_heap_checker.sv */
// Scoreboard for the timer min-heap scheduler: watches both channels, predicts
// each result from a private heap model and compares. Depends on tmhs_pkg.
`timescale 1ns / 1ps

module tb_timer_min_heap_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [tmhs_pkg::REQ_W-1:0]    i_req_type,
    input  logic [tmhs_pkg::ID_W-1:0]     i_timer_id,
    input  logic [tmhs_pkg::DELAY_W-1:0]  i_delay_ms,
    input  logic [tmhs_pkg::NOW_W-1:0]    i_now_us,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [tmhs_pkg::STATUS_W-1:0] i_status,
    input  logic [tmhs_pkg::ID_W-1:0]     i_expired_id,
    input  logic [tmhs_pkg::NOW_W-1:0]    i_wait_us,
    input  logic [tmhs_pkg::COUNT_W-1:0]  i_active_count,
    output int                            o_fail_count,
    output int                            o_pending
);
    import tmhs_pkg::*;

    localparam int          HEAP_SLOTS = DEF_CAPACITY;
    localparam logic [63:0] DL_MAX     = 64'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     expired_id;
        logic [NOW_W-1:0]    wait_us;
        logic [COUNT_W-1:0]  active_count;
    } t_reply;

    logic [NOW_W-1:0] heap_deadline [HEAP_SLOTS];
    logic [ID_W-1:0]  heap_owner    [HEAP_SLOTS];
    int               slot_of_id    [ID_SPACE];
    bit               id_live       [ID_SPACE];
    int               live_total;
    t_reply           awaited_replies[$];
    int               fails;

    assign o_fail_count = fails;
    assign o_pending    = awaited_replies.size();

    initial begin
        fails      = 0;
        live_total = 0;
        foreach (id_live[k]) id_live[k] = 1'b0;
    end

    function automatic void put_slot(int pos, logic [NOW_W-1:0] dl, logic [ID_W-1:0] id);
        heap_deadline[pos] = dl;
        heap_owner[pos]    = id;
        slot_of_id[id]     = pos;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [NOW_W-1:0] da;
        logic [ID_W-1:0]  ia;
        da = heap_deadline[a];
        ia = heap_owner[a];
        put_slot(a, heap_deadline[b], heap_owner[b]);
        put_slot(b, da, ia);
    endfunction

    // Climb while the parent is not strictly earlier.
    function automatic void climb(int pos);
        int par;
        while (pos > 0 && pos < live_total) begin
            par = (pos - 1) / 2;
            if (heap_deadline[par] < heap_deadline[pos]) break;
            swap_slots(pos, par);
            pos = par;
        end
    endfunction

    // Descend: left child unless the right is strictly earlier; stop when
    // the item is strictly earlier than that child.
    function automatic void descend(int pos);
        int kid;
        while (pos < live_total) begin
            kid = pos * 2 + 1;
            if (kid >= live_total) break;
            if (kid + 1 < live_total && heap_deadline[kid] > heap_deadline[kid+1])
                kid = kid + 1;
            if (heap_deadline[pos] < heap_deadline[kid]) break;
            swap_slots(pos, kid);
            pos = kid;
        end
    endfunction

    function automatic void drop_timer(logic [ID_W-1:0] id);
        int              hole;
        logic [ID_W-1:0] moved;
        hole        = slot_of_id[id];
        id_live[id] = 1'b0;
        if (live_total == 0) return;
        live_total--;
        if (hole >= live_total) return;
        moved = heap_owner[live_total];
        put_slot(hole, heap_deadline[live_total], moved);
        descend(hole);
        climb(slot_of_id[moved]);
    endfunction

    function automatic t_reply predict_request(logic [REQ_W-1:0] req, logic [ID_W-1:0] id,
                                               logic [DELAY_W-1:0] delay,
                                               logic [NOW_W-1:0] now);
        t_reply      r;
        logic [63:0] dl;
        r = '0;
        case (t_req'(req))
            REQ_INSERT: begin
                if (live_total >= HEAP_SLOTS) begin
                    r.status = ST_FULL;
                end else if (id_live[id]) begin
                    r.status = ST_ACTIVE;
                end else begin
                    dl = 64'(now) + 64'(delay) * 64'(MS_TO_US);
                    if (dl > DL_MAX) dl = DL_MAX;
                    put_slot(live_total, dl[NOW_W-1:0], id);
                    id_live[id] = 1'b1;
                    live_total++;
                    climb(live_total - 1);
                    r.status = ST_OK;
                end
            end
            REQ_CANCEL: begin
                if (!id_live[id]) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    drop_timer(id);
                    r.status = ST_OK;
                end
            end
            REQ_POLL: begin
                if (live_total == 0) begin
                    r.status = ST_EMPTY;
                end else if (heap_deadline[0] < now) begin
                    r.expired_id = heap_owner[0];
                    drop_timer(heap_owner[0]);
                    r.status = ST_EXPIRED;
                end else begin
                    r.wait_us = heap_deadline[0] - now;
                    r.status  = ST_NOT_DUE;
                end
            end
            default: r.status = ST_OK;
        endcase
        r.active_count = COUNT_W'(live_total);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply got;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                awaited_replies.push_back(predict_request(i_req_type, i_timer_id,
                                                          i_delay_ms, i_now_us));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_expired_id, i_wait_us, i_active_count};
                if (awaited_replies.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display({"%0t: result beat with nothing pending: ",
                                  "st=%0d id=%0d wait=%0d cnt=%0d"},
                                 $realtime, got.status, got.expired_id, got.wait_us,
                                 got.active_count);
                end else begin
                    want = awaited_replies.pop_front();
                    if (want != got) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: mismatch exp st=%0d id=%0d wait=%0d cnt=%0d",
                                      " | got st=%0d id=%0d wait=%0d cnt=%0d"},
                                     $realtime, want.status, want.expired_id, want.wait_us,
                                     want.active_count, got.status, got.expired_id,
                                     got.wait_us, got.active_count);
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_timer_min_heap_scheduler.sv */
// Top of the timer min-heap scheduler testbench: clock, reset, request stimulus,
// result-side stall, watchdog and verdict. Depends on tmhs_pkg and the checker.
`timescale 1ns / 1ps

module tb_timer_min_heap_scheduler;
    import tmhs_pkg::*;

    // Watchdog: the limit covers the reset clearing pass and the long receiver
    // hold-off, so this leaves plenty of margin.
    localparam int QUIET_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;
    localparam int RAND_PER_PHASE = 100;
    localparam int FILL_COUNT = 64;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [REQ_W-1:0]    i_req_type;
    logic [ID_W-1:0]     i_timer_id;
    logic [DELAY_W-1:0]  i_delay_ms;
    logic [NOW_W-1:0]    i_now_us;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_expired_id;
    logic [NOW_W-1:0]    o_wait_us;
    logic [COUNT_W-1:0]  o_active_count;

    int               fail_count;
    int               pending;
    int               tx_idle_pct;
    int               rx_idle_pct;
    logic             rx_hold;
    int               quiet_cycles;
    logic [NOW_W-1:0] clock_now;

    timer_min_heap_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_timer_id     (i_timer_id),
        .i_delay_ms     (i_delay_ms),
        .i_now_us       (i_now_us),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_expired_id   (o_expired_id),
        .o_wait_us      (o_wait_us),
        .o_active_count (o_active_count)
    );

    tb_timer_min_heap_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_timer_id     (i_timer_id),
        .i_delay_ms     (i_delay_ms),
        .i_now_us       (i_now_us),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_expired_id   (o_expired_id),
        .i_wait_us      (o_wait_us),
        .i_active_count (o_active_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Result side: random stall per cycle, or hold high during a hold-off.
    always @(posedge i_clk) begin
        i_out_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one request beat and hold it until accepted. Sender gaps come
    // first, so valid stays high between back-to-back beats.
    task automatic send_request(t_req req, logic [ID_W-1:0] id,
                                logic [DELAY_W-1:0] delay, logic [NOW_W-1:0] now);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_timer_id <= id;
        i_delay_ms <= delay;
        i_now_us   <= now;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        // Mostly a small pool so inserts and cancels hit live timers.
        if ($urandom_range(99) < 80) return ID_W'($urandom_range(0, 47));
        return ID_W'($urandom);
    endfunction

    function automatic logic [NOW_W-1:0] random_time();
        return NOW_W'({$urandom, $urandom});
    endfunction

    task automatic random_requests(int n);
        int               r;
        logic [DELAY_W-1:0] d;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) begin
                case ($urandom_range(19))
                    0, 1, 2: d = DELAY_W'($urandom);
                    3, 4:    d = {DELAY_W{1'b1}};
                    5:       d = '0;
                    default: d = DELAY_W'($urandom_range(0, 30));
                endcase
                send_request(REQ_INSERT, pick_id(), d,
                             ($urandom_range(29) == 0) ? random_time() : clock_now);
            end else if (r < 70) begin
                send_request(REQ_CANCEL, pick_id(), DELAY_W'($urandom), random_time());
            end else if (r < 95) begin
                // Advance the clock so timers come due and expire.
                clock_now = clock_now + NOW_W'($urandom_range(0, 20000));
                send_request(REQ_POLL, ID_W'($urandom), DELAY_W'($urandom),
                             ($urandom_range(19) == 0) ? random_time() : clock_now);
            end else begin
                send_request(REQ_NONE, ID_W'($urandom), DELAY_W'($urandom), random_time());
            end
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_out_stall  = 1'b0;
        i_req_type   = REQ_NONE;
        i_timer_id   = '0;
        i_delay_ms   = '0;
        i_now_us     = '0;
        rx_hold      = 1'b0;
        tx_idle_pct  = 19;
        rx_idle_pct  = 79;
        quiet_cycles = 0;
        clock_now    = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty poll, unknown cancel, unused code, saturation,
        // duplicate id, ties, exact-due poll, expiry, last-entry cancel.
        send_request(REQ_POLL,   12'd0,    '0, '0);
        send_request(REQ_CANCEL, 12'd4095, '0, '0);
        send_request(REQ_NONE,   12'd4095, {DELAY_W{1'b1}}, {NOW_W{1'b1}});
        send_request(REQ_INSERT, 12'd4095, {DELAY_W{1'b1}}, {NOW_W{1'b1}});
        send_request(REQ_INSERT, 12'd4095, '0, '0);
        send_request(REQ_INSERT, 12'd0,    '0, '0);
        send_request(REQ_INSERT, 12'd5,    31'd1, '0);
        send_request(REQ_INSERT, 12'd6,    31'd1, '0);
        send_request(REQ_INSERT, 12'd7,    31'd1, '0);
        send_request(REQ_INSERT, 12'd8,    '0, 48'd1000);
        send_request(REQ_POLL,   12'd0,    '0, 48'd0);
        send_request(REQ_POLL,   12'd0,    '0, 48'd1);
        send_request(REQ_POLL,   12'd0,    '0, 48'd1000);
        send_request(REQ_CANCEL, 12'd6,    '0, '0);
        send_request(REQ_CANCEL, 12'd4095, '0, '0);
        send_request(REQ_CANCEL, 12'd4095, '0, '0);
        send_request(REQ_POLL,   12'd0,    '0, 48'd1001);
        send_request(REQ_POLL,   12'd0,    '0, 48'd1001);
        send_request(REQ_POLL,   12'd0,    '0, 48'd1001);
        send_request(REQ_POLL,   12'd0,    '0, {NOW_W{1'b1}});
        send_request(REQ_POLL,   12'd0,    '0, {NOW_W{1'b1}});
        drain_results();

        // Phase one: sender idles lightly, receiver heavily. Hold the result
        // side off for a long stretch so the block backs up into its input.
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        random_requests(RAND_PER_PHASE);
        drain_results();

        // Phase two: swap the idling.
        tx_idle_pct = 79;
        rx_idle_pct = 19;
        random_requests(RAND_PER_PHASE);
        drain_results();

        // Phase three: no idling. Build a deeper heap, retry an active id,
        // then cancel every filled id in a scattered order to walk deep.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int k = 0; k < FILL_COUNT; k++)
            send_request(REQ_INSERT, ID_W'(k), DELAY_W'($urandom_range(0, 40)),
                         NOW_W'($urandom_range(0, 3000)));
        send_request(REQ_INSERT, 12'd0, '0, '0);
        send_request(REQ_INSERT, ID_W'($urandom), DELAY_W'($urandom), random_time());
        send_request(REQ_POLL,   12'd0, '0, '0);
        for (int k = 0; k < FILL_COUNT; k++)
            send_request(REQ_CANCEL, ID_W'((k * 37) % FILL_COUNT), '0, '0);
        send_request(REQ_POLL, 12'd0, '0, '0);
        clock_now = '0;
        random_requests(RAND_PER_PHASE);
        drain_results();

        repeat (64) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
